FILE: rtl/lirc_pkg.sv
`default_nettype none

package lirc_pkg;

  // Depth of the impulse response store and of the sample history.
  localparam int MAX_TAPS = 256;
  localparam int TAP_W    = $clog2(MAX_TAPS);

  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 8;
  localparam int TAPCNT_W = 9;
  localparam int FRAC_W   = 15;
  localparam int PROD_W   = 2 * SAMPLE_W;
  // Products are Q2.30; the sum of MAX_TAPS of them needs TAP_W more bits and a guard bit.
  localparam int ACC_W    = PROD_W + TAP_W + 1;
  localparam int CMP_W    = (TAP_W + 1 > TAPCNT_W) ? TAP_W + 1 : TAPCNT_W;

  localparam logic KIND_COEF   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic shift_in;
    logic rotate;
  } cell_ctrl_t;

  typedef struct packed {
    logic term_en;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/lirc_cell.sv
`default_nettype none

module lirc_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lirc_pkg::cell_ctrl_t                 ctrl_i,
  input  logic                                 coef_we_i,
  input  logic signed [lirc_pkg::SAMPLE_W-1:0] coef_wdata_i,
  input  logic signed [lirc_pkg::SAMPLE_W-1:0] samp_prev_i,
  input  logic signed [lirc_pkg::SAMPLE_W-1:0] coef_next_i,
  input  logic signed [lirc_pkg::SAMPLE_W-1:0] samp_next_i,
  output logic signed [lirc_pkg::SAMPLE_W-1:0] coef_o,
  output logic signed [lirc_pkg::SAMPLE_W-1:0] samp_o
);
  import lirc_pkg::*;

  logic signed [SAMPLE_W-1:0] coef_q, coef_d;
  logic signed [SAMPLE_W-1:0] samp_q, samp_d;

  // While rotating, both words move one cell towards the head of the ring.
  // A new sample pushes the history one cell away from the head.
  always_comb begin
    coef_d = coef_q;
    samp_d = samp_q;
    priority if (ctrl_i.rotate) begin
      coef_d = coef_next_i;
      samp_d = samp_next_i;
    end else if (ctrl_i.shift_in) begin
      samp_d = samp_prev_i;
    end else if (coef_we_i) begin
      coef_d = coef_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
      samp_q <= '0;
    end else begin
      coef_q <= coef_d;
      samp_q <= samp_d;
    end
  end

  assign coef_o = coef_q;
  assign samp_o = samp_q;

endmodule

`default_nettype wire

FILE: rtl/lirc_mac.sv
`default_nettype none

module lirc_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lirc_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [lirc_pkg::SAMPLE_W-1:0] coef_i,
  input  logic signed [lirc_pkg::SAMPLE_W-1:0] samp_i,
  output logic                                 res_valid_o,
  output logic signed [lirc_pkg::SAMPLE_W-1:0] res_o
);
  import lirc_pkg::*;

  localparam int RND_W = ACC_W - FRAC_W;
  localparam logic signed [RND_W-1:0] SAT_MAX = $signed(RND_W'(32767));
  localparam logic signed [RND_W-1:0] SAT_MIN = $signed(RND_W'(-32768));
  localparam logic signed [ACC_W-1:0] HALF    = $signed(ACC_W'(1 << (FRAC_W - 1)));

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  biased;
  logic signed [RND_W-1:0]  rnd;
  logic                     first_q, last_q, res_valid_q;

  // Terms beyond the tap count enter as zero.
  assign prod_d = ctrl_i.term_en ? PROD_W'(coef_i) * PROD_W'(samp_i) : '0;
  assign acc_d  = first_q ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= 1'b0;
      last_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      first_q <= ctrl_i.first;
      last_q  <= ctrl_i.last;
      if (ctrl_i.first) begin
        res_valid_q <= 1'b0;
      end else if (last_q) begin
        res_valid_q <= 1'b1;
      end
    end
  end

  // Halves round towards plus infinity, then the result is clipped to Q1.15.
  assign biased = acc_q + HALF;
  assign rnd    = $signed(biased[ACC_W-1:FRAC_W]);

  always_comb begin
    priority if (rnd > SAT_MAX) begin
      res_o = SAT_MAX[SAMPLE_W-1:0];
    end else if (rnd < SAT_MIN) begin
      res_o = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      res_o = rnd[SAMPLE_W-1:0];
    end
  end

  assign res_valid_o = res_valid_q;

endmodule

`default_nettype wire

FILE: rtl/long_ir_convolver.sv
`default_nettype none

// Channel   Direction  tdata                                  tuser
// s_axis    in         [7:0] tap_index, [23:8] value          [0] kind (0 coef, 1 sample)
// m_axis    out        [15:0] output_sample                   -
// cfg       in         cfg_wdata_i[8:0] tap_count, no handshake
//
// A coefficient word is written into its cell and the input stays ready. A sample word
// holds the input off until its pass ends: the ring of cells rotates once past the single
// multiply-accumulate unit at its head, one tap per cycle, then the pipeline drains.
// Reset clears every cell at once; no clearing pass is needed.
// A stalled output holds its word; the next sample is still taken and waits only at
// the end of its own pass until the output register is free.
module long_ir_convolver (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [23:0]                       s_axis_tdata_i,  // [7:0] tap_index, [23:8] value
  input  logic                              s_axis_tuser_i,  // [0] kind
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [15:0]                       m_axis_tdata_o,  // [15:0] output_sample
  input  logic                              cfg_we_i,
  input  logic [lirc_pkg::TAPCNT_W-1:0]     cfg_wdata_i      // [8:0] tap_count
);
  import lirc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(MAX_TAPS - 1);

  state_e                 state_q;
  logic [TAP_W-1:0]       cnt_q;
  logic [TAPCNT_W-1:0]    tap_count_q;
  logic                   out_valid_q;
  logic [SAMPLE_W-1:0]    out_data_q;

  logic                       s_accept;
  logic                       is_sample;
  logic [INDEX_W-1:0]         in_index;
  logic signed [SAMPLE_W-1:0] in_value;
  cell_ctrl_t                 cell_ctrl;
  mac_ctrl_t                  mac_ctrl;
  logic                       mac_res_valid;
  logic signed [SAMPLE_W-1:0] mac_res;
  logic                       out_free;

  logic signed [SAMPLE_W-1:0] coef_w [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] samp_w [MAX_TAPS];

  assign in_index  = s_axis_tdata_i[INDEX_W-1:0];
  assign in_value  = $signed(s_axis_tdata_i[INDEX_W+SAMPLE_W-1:INDEX_W]);
  assign is_sample = (s_axis_tuser_i == KIND_SAMPLE);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign cell_ctrl.shift_in = s_accept && is_sample;
  assign cell_ctrl.rotate   = (state_q == ST_RUN);

  assign mac_ctrl.term_en = (state_q == ST_RUN) &&
                            (CMP_W'(cnt_q) < CMP_W'(tap_count_q));
  assign mac_ctrl.first   = (state_q == ST_RUN) && (cnt_q == '0);
  assign mac_ctrl.last    = (state_q == ST_RUN) && (cnt_q == LAST_TAP);

  // Cell k holds tap k and the sample k words old; the ring closes from the last cell
  // back to the head.
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    logic coef_we;
    assign coef_we = s_accept && !is_sample && (int'(in_index) == k);

    lirc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .coef_we_i    (coef_we),
      .coef_wdata_i (in_value),
      .samp_prev_i  ((k == 0) ? in_value : samp_w[(k + MAX_TAPS - 1) % MAX_TAPS]),
      .coef_next_i  (coef_w[(k + 1) % MAX_TAPS]),
      .samp_next_i  (samp_w[(k + 1) % MAX_TAPS]),
      .coef_o       (coef_w[k]),
      .samp_o       (samp_w[k])
    );
  end

  lirc_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mac_ctrl),
    .coef_i      (coef_w[0]),
    .samp_i      (samp_w[0]),
    .res_valid_o (mac_res_valid),
    .res_o       (mac_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      tap_count_q <= TAPCNT_W'(1);
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        tap_count_q <= cfg_wdata_i;
      end
      if (state_q == ST_FINISH && mac_res_valid && out_free) begin
        out_valid_q <= 1'b1;
        out_data_q  <= mac_res;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_accept && is_sample) begin
            cnt_q   <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          cnt_q <= cnt_q + TAP_W'(1);
          if (cnt_q == LAST_TAP) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (mac_res_valid && out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  a_sample_starts_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && is_sample) |=> (state_q == ST_RUN) && (cnt_q == '0))
    else $error("sample word did not start a pass of the ring");

  a_coef_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && !is_sample) |=> (state_q == ST_IDLE) && !$rose(out_valid_q))
    else $error("coefficient word produced activity");

  a_pass_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && cnt_q == LAST_TAP) |=> (state_q == ST_FINISH))
    else $error("pass did not end after the last cell");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH && mac_res_valid))
    else $error("output word loaded outside the end of a pass");
`endif

endmodule

`default_nettype wire
